FILE: rtl/lss_pkg.sv
package lss_pkg;

  // Default stack depth and field widths of the transactions
  localparam int unsigned DEPTH_DEF  = 256;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CAP_W      = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

endpackage

FILE: rtl/lss_store.sv
module lss_store
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WORD_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WORD_W-1:0]        rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lifo_stack_with_search_top.sv
// Bounded LIFO stack of 32-bit signed words with a top-down search. One
// transaction is taken at a time: in_ready is high only while the sequencer
// is idle. Push, clear and unused codes go from the execute step straight to
// the done step; pop and peek add a fetch step when the stack holds an entry
// (one registered read of the stack memory) and skip it when it is empty, and
// search adds a scan step that examines entries from the top down (at most
// count); the single read port of the stack memory delivers one entry per
// cycle to the comparator.
// A result waiting on out_ready holds the sequencer in its final step. The
// capacity register is clamped to DEPTH and should be written while idle.
module lifo_stack_with_search_top
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  state_t                state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [WORD_W-1:0]     key_r, key_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [WORD_W-1:0]     data_r, data_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  logic                  mem_we;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_W-1:0]     mem_rdata;
  logic [CMPW-1:0]       cap_eff;
  logic                  full;
  logic                  empty;

  // Stack memory
  lss_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(count_r)),
    .wdata (key_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Clamp capacity to depth and derive flags
  assign cap_eff = (CMPW'(cap_r) > DEPTH_C) ? DEPTH_C : CMPW'(cap_r);
  assign full    = (CMPW'(count_r) >= cap_eff);
  assign empty   = (count_r == '0);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: next state, memory control and result assembly
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    cap_nxt       = cfg_wr_en ? cfg_wr_data : cap_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_raddr     = AW'(count_r - 1'b1);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          key_nxt    = in_data.value;
          status_nxt = ST_OK;
          data_nxt   = '0;
          pos_nxt    = '0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_PUSH: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          OP_POP, OP_PEEK: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_FETCH;
              if (op_r == OP_POP) begin
                count_nxt = count_r - 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            count_nxt = '0;
          end
          OP_SEARCH: begin
            if (empty) begin
              status_nxt = ST_MISS;
            end else begin
              idx_nxt   = AW'(count_r - 1'b1);
              state_nxt = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_FETCH: begin
        data_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // Compare the entry at idx_r and fetch the one below it
        mem_raddr = idx_r - 1'b1;
        if (mem_rdata == key_r) begin
          pos_nxt   = idx_r;
          state_nxt = S_DONE;
        end else if (idx_r == '0) begin
          status_nxt = ST_MISS;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.status   = status_r;
          out_data_nxt.data     = data_r;
          out_data_nxt.position = POS_W'(pos_r);
          out_data_nxt.count    = COUNT_W'(count_r);
          out_data_nxt.is_empty = empty;
          out_data_nxt.is_full  = full;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    status_r   <= status_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // Count never exceeds the stack depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= DEPTH_C)
    else $error("stack count above depth");

  // An accepted transaction closes the input until its result is done
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

  // Scan index stays within the filled part of the stack
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(idx_r) < count_r))
    else $error("search index outside stack");

  // A push never passes the capacity
  a_push_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r) && count_r == $past(count_r) + 1'b1 && $past(rst_n))
      |-> (CMPW'($past(count_r)) < $past(cap_eff)))
    else $error("push beyond capacity");
`endif

endmodule
